[src/rdt_pkg.sv]
// Package for the record deduplication table.
// Holds the sizing constants and the IEEE double equality function.
// No dependencies.
`default_nettype none
package rdt_pkg;
    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_WORDS   = 16;
    localparam int WORD_W      = 64;
    localparam int WPOS_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ENT_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = ENT_W + WPOS_W;
    localparam int DEPTH       = MAX_ENTRIES * MAX_WORDS;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 10;
    localparam int UCNT_W      = 11;
    localparam int DCNT_W      = 32;

    // IEEE double equality: NaN matches nothing, +0 equals -0.
    function automatic logic dbl_equal(input logic [WORD_W-1:0] a,
                                       input logic [WORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        zeros = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return !a_nan && !b_nan && ((a == b) || zeros);
    endfunction
endpackage
`default_nettype wire

[src/rdt_table_ram.sv]
// Synchronous single-port table memory with a registered read port.
// Depends on rdt_pkg.
`default_nettype none
module rdt_table_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [rdt_pkg::ADDR_W-1:0]  i_addr,
    input  wire logic [rdt_pkg::WORD_W-1:0]  i_wdata,
    output logic      [rdt_pkg::WORD_W-1:0]  o_rdata
);
    import rdt_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[src/record_dedup_table.sv]
// Record deduplication table. A word that ends no record is stored without leaving idle.
// A final word keeps busy high while entries are scanned (a read and a compare state
// per table word, stopping at the first match; straight to compare when the table is
// empty), while a new record is appended word by word, and through the result state.
// No new word is taken while busy; the receiver cannot stall. Synchronous
// active-low reset clears counters and control; table and record buffer stay undefined.
`default_nettype none
module record_dedup_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [63:0]                 i_word,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [4:0]                  i_cfg_record_words,
    output logic                             o_strobe,
    output logic                             o_is_duplicate,
    output logic [9:0]                       o_match_index,
    output logic                             o_dropped_full,
    output logic [10:0]                      o_unique_count,
    output logic [31:0]                      o_duplicate_count
);
    import rdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CHECK, S_WRITE, S_DONE
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_buf [MAX_WORDS];
    logic [WPOS_W-1:0]   r_pos;
    logic [LEN_W-1:0]    r_len_reg;
    logic [CNT_W-1:0]    r_entries;
    logic [DCNT_W-1:0]   r_dups;
    logic [ENT_W-1:0]    r_ent;       // entry under scan
    logic [WPOS_W-1:0]   r_wsel;      // word being read or written
    logic [WPOS_W-1:0]   r_rword;     // word whose read data lands now
    logic                r_rvalid;
    logic                r_rlast;
    logic                r_eq;        // running match of current entry
    logic [WPOS_W:0]     w_len;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                w_hit;

    // Effective record length: zero acts as one, clamp to MAX_WORDS.
    always_comb begin
        if (r_len_reg == '0) begin
            w_len = (WPOS_W+1)'(1);
        end else if (32'(r_len_reg) > MAX_WORDS) begin
            w_len = (WPOS_W+1)'(MAX_WORDS);
        end else begin
            w_len = (WPOS_W+1)'(r_len_reg);
        end
    end

    assign ram_we   = (r_state == S_WRITE);
    assign ram_addr = {r_ent, r_wsel};
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign w_hit = r_eq && dbl_equal(r_buf[r_rword], ram_rdata);

    rdt_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_buf[r_wsel]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_len_reg <= LEN_W'(1);
            r_entries <= '0;
            r_dups    <= '0;
            r_rvalid  <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_rvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_len_reg <= i_cfg_record_words;
                        r_pos     <= '0;
                    end else if (start) begin
                        r_buf[r_pos] <= i_word;
                        r_ent  <= '0;
                        r_wsel <= '0;
                        r_eq   <= 1'b1;
                        if ((WPOS_W+1)'(r_pos) + 1'b1 >= w_len) begin
                            r_pos <= '0;
                            if (r_entries == '0) begin
                                r_state <= S_CHECK;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue reads; the compare follows in the next cycle.
                    r_rvalid <= 1'b1;
                    r_rword  <= r_wsel;
                    r_rlast  <= ((WPOS_W+1)'(r_wsel) + 1'b1 == w_len);
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_entries == '0) begin
                        r_state <= S_WRITE;
                        r_ent   <= ENT_W'(r_entries);
                        r_wsel  <= '0;
                    end else if (r_rvalid) begin
                        if (r_rlast) begin
                            if (w_hit) begin
                                o_strobe          <= 1'b1;
                                o_is_duplicate    <= 1'b1;
                                o_match_index     <= IDX_W'(r_ent);
                                o_dropped_full    <= 1'b0;
                                o_unique_count    <= UCNT_W'(r_entries);
                                o_duplicate_count <= (r_dups == '1) ? r_dups
                                                                    : r_dups + 1'b1;
                                if (r_dups != '1) r_dups <= r_dups + 1'b1;
                                r_state <= S_DONE;
                            end else if (CNT_W'(r_ent) + 1'b1 >= r_entries) begin
                                if (32'(r_entries) >= MAX_ENTRIES) begin
                                    o_strobe          <= 1'b1;
                                    o_is_duplicate    <= 1'b0;
                                    o_match_index     <= '0;
                                    o_dropped_full    <= 1'b1;
                                    o_unique_count    <= UCNT_W'(r_entries);
                                    o_duplicate_count <= r_dups;
                                    r_state <= S_DONE;
                                end else begin
                                    r_ent   <= ENT_W'(r_entries);
                                    r_wsel  <= '0;
                                    r_state <= S_WRITE;
                                end
                            end else begin
                                r_ent   <= r_ent + 1'b1;
                                r_wsel  <= '0;
                                r_eq    <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_eq    <= w_hit;
                            r_wsel  <= r_wsel + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_WRITE: begin
                    if ((WPOS_W+1)'(r_wsel) + 1'b1 >= w_len) begin
                        o_strobe          <= 1'b1;
                        o_is_duplicate    <= 1'b0;
                        o_match_index     <= IDX_W'(r_entries);
                        o_dropped_full    <= 1'b0;
                        o_unique_count    <= UCNT_W'(r_entries + 1'b1);
                        o_duplicate_count <= r_dups;
                        r_entries         <= r_entries + 1'b1;
                        r_state           <= S_DONE;
                    end else begin
                        r_wsel <= r_wsel + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The table never holds more than its capacity.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_entries) <= MAX_ENTRIES) else $error("entry count overflow");
    // A result is only produced while a record is being processed.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == S_DONE) else $error("stray strobe");
    // Table writes happen only after a record was taken.
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy) else $error("write while idle");
    // A full table never grows.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_dropped_full) |-> $stable(r_entries))
        else $error("drop changed count");
endmodule
`default_nettype wire
